[hw/rtl/nvq_pkg.sv]
// ----------------------------------------------------------------------------
// nvq_pkg: shared constants and codebook for the normal vector quantizer
// Holds the 24-point sphere codebook in Q1.15 and a helper that rescales a
// codebook component to the configured component width.
// ----------------------------------------------------------------------------
package nvq_pkg;

	// Codebook geometry.
	localparam int TABLE_CODES        = 24;
	localparam int BASE_BITS          = 16;
	localparam int IDX_W              = 5;

	// Defaults for the top-level parameters.
	localparam int DEF_NUM_CODES      = 24;
	localparam int DEF_COMPONENT_BITS = 16;

	// Unit directions spread evenly over the sphere, x/y/z in Q1.15.
	localparam int CODEBOOK [TABLE_CODES][3] = '{
		'{     0,  32767,      0},
		'{ -9855,  29918,   9028},
		'{  1614,  27068, -18395},
		'{ 13429,  24219,  17515},
		'{-24460,  21370,  -4327},
		'{ 22807,  18520, -14508},
		'{ -7471,  15671,  27790},
		'{-13898,  12822, -26760},
		'{ 29319,   9973,  10707},
		'{-29564,   7123,  12203},
		'{ 13770,   4274, -29425},
		'{  9797,   1425,  31236},
		'{-28324,  -1425, -16414},
		'{ 31729,  -4274,  -6976},
		'{-18395,  -7123,  26164},
		'{ -4011,  -9973, -30954},
		'{ 23057, -12822,  19433},
		'{-28752, -15671,   1189},
		'{ 19160, -18520, -19067},
		'{ -1147, -21370,  24813},
		'{-14141, -24219, -16945},
		'{ 18301, -27068,   2462},
		'{-10970, -29918,   7633},
		'{     0, -32767,      0}
	};

	// Number of codewords actually searched.
	function automatic int code_limit(int num_codes);
		return (num_codes < TABLE_CODES) ? num_codes : TABLE_CODES;
	endfunction

	// Codebook component scaled to the given width. Narrowing truncates
	// toward zero, so negative values are shifted as magnitudes.
	function automatic int scaled_code(int idx, int comp, int bits);
		int c;
		c = CODEBOOK[idx][comp];
		if (bits >= BASE_BITS) begin
			return c <<< (bits - BASE_BITS);
		end else if (c < 0) begin
			return -((-c) >>> (BASE_BITS - bits));
		end else begin
			return c >>> (BASE_BITS - bits);
		end
	endfunction

endpackage

[hw/rtl/nvq_sample_if.sv]
// ----------------------------------------------------------------------------
// nvq_sample_if: input channel of the normal vector quantizer
// Carries one surface normal per item under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nvq_sample_if
	import nvq_pkg::*;
#(
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) ();

	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] normal_x;
	logic signed [COMPONENT_BITS-1:0] normal_y;
	logic signed [COMPONENT_BITS-1:0] normal_z;

	modport source (output valid, output normal_x, output normal_y, output normal_z,
		input ready);
	modport sink (input valid, input normal_x, input normal_y, input normal_z,
		output ready);

endinterface

[hw/rtl/nvq_result_if.sv]
// ----------------------------------------------------------------------------
// nvq_result_if: output channel of the normal vector quantizer
// Carries the winning codeword index and its direction per item.
// ----------------------------------------------------------------------------
interface nvq_result_if
	import nvq_pkg::*;
#(
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) ();

	logic                             valid;
	logic                             ready;
	logic        [IDX_W-1:0]          cluster_index;
	logic signed [COMPONENT_BITS-1:0] code_x;
	logic signed [COMPONENT_BITS-1:0] code_y;
	logic signed [COMPONENT_BITS-1:0] code_z;

	modport source (output valid, output cluster_index, output code_x, output code_y,
		output code_z, input ready);
	modport sink (input valid, input cluster_index, input code_x, input code_y,
		input code_z, output ready);

endinterface

[hw/rtl/nvq_cell.sv]
// ----------------------------------------------------------------------------
// nvq_cell: one codeword cell of the search chain
// Squares the distance terms to its own codeword and, in the same cycle,
// folds the previous cell's codeword distance, if any, into the running best.
// ----------------------------------------------------------------------------
module nvq_cell
	import nvq_pkg::*;
#(
	parameter int CODE_IDX       = 0,
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
	localparam int CB            = COMPONENT_BITS,
	localparam int SQ_W          = 2 * CB,
	localparam int DW            = 2 * CB + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Upstream side.
	input  logic                  valid_i,
	output logic                  ready_o,
	input  logic signed [CB-1:0]  vec_i [3],
	input  logic        [SQ_W-1:0] sq_i [3],
	input  logic        [DW-1:0]  best_d_i,
	input  logic        [IDX_W-1:0] best_idx_i,
	// Downstream side.
	output logic                  valid_o,
	input  logic                  ready_i,
	output logic signed [CB-1:0]  vec_o [3],
	output logic        [SQ_W-1:0] sq_o [3],
	output logic        [DW-1:0]  best_d_o,
	output logic        [IDX_W-1:0] best_idx_o
);

	localparam logic signed [CB:0] CODE [3] = '{
		(CB+1)'(scaled_code(CODE_IDX, 0, CB)),
		(CB+1)'(scaled_code(CODE_IDX, 1, CB)),
		(CB+1)'(scaled_code(CODE_IDX, 2, CB))
	};
	localparam logic [IDX_W-1:0] PREV_IDX = IDX_W'(CODE_IDX - 1);

	logic                   valid_q;
	logic signed [CB-1:0]   vec_q [3];
	logic        [SQ_W-1:0] sq_q [3];
	logic        [DW-1:0]   best_d_q;
	logic        [IDX_W-1:0] best_idx_q;

	logic signed [CB:0]     diff [3];
	logic signed [DW-1:0]   prod [3];
	logic        [SQ_W-1:0] sq_next [3];
	logic        [DW-1:0]   best_d_next;
	logic        [IDX_W-1:0] best_idx_next;
	logic                   load;

	// The cell advances whenever it is empty or its neighbor takes its item.
	assign ready_o = !valid_q || ready_i;
	assign load    = valid_i && ready_o;

	// Squared distance terms to this cell's codeword.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c]    = {vec_i[c][CB-1], vec_i[c]} - CODE[c];
			prod[c]    = diff[c] * diff[c];
			sq_next[c] = prod[c][SQ_W-1:0];
		end
	end

	// Compare the previous codeword's distance against the running best.
	generate
		if (CODE_IDX == 0) begin : g_first
			assign best_d_next   = best_d_i;
			assign best_idx_next = best_idx_i;
		end else begin : g_compare
			logic [DW-1:0] d_prev;
			assign d_prev = DW'(sq_i[0]) + DW'(sq_i[1]) + DW'(sq_i[2]);
			always_comb begin
				if (d_prev < best_d_i) begin
					best_d_next   = d_prev;
					best_idx_next = PREV_IDX;
				end else begin
					best_d_next   = best_d_i;
					best_idx_next = best_idx_i;
				end
			end
		end
	endgenerate

	// Item valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load) begin
			vec_q      <= vec_i;
			sq_q       <= sq_next;
			best_d_q   <= best_d_next;
			best_idx_q <= best_idx_next;
		end
	end

	assign valid_o    = valid_q;
	assign vec_o      = vec_q;
	assign sq_o       = sq_q;
	assign best_d_o   = best_d_q;
	assign best_idx_o = best_idx_q;

endmodule

[hw/rtl/nvq_out_stage.sv]
// ----------------------------------------------------------------------------
// nvq_out_stage: final compare and codeword lookup
// Folds in the last codeword's distance, looks up the winning direction and
// holds the result item until the receiver takes it.
// ----------------------------------------------------------------------------
module nvq_out_stage
	import nvq_pkg::*;
#(
	parameter int NUM_CODES      = DEF_NUM_CODES,
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
	localparam int CB            = COMPONENT_BITS,
	localparam int SQ_W          = 2 * CB,
	localparam int DW            = 2 * CB + 2,
	localparam int LIMIT         = code_limit(NUM_CODES),
	localparam int TAB_DEPTH     = 2 ** IDX_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_i,
	output logic                   ready_o,
	input  logic        [SQ_W-1:0] sq_i [3],
	input  logic        [DW-1:0]   best_d_i,
	input  logic        [IDX_W-1:0] best_idx_i,
	output logic                   valid_o,
	input  logic                   ready_i,
	output logic        [IDX_W-1:0] idx_o,
	output logic signed [CB-1:0]   code_o [3]
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMIT - 1);

	logic signed [CB-1:0]   tab [TAB_DEPTH][3];
	logic        [DW-1:0]   d_last;
	logic        [IDX_W-1:0] sel;
	logic                   valid_q;
	logic        [IDX_W-1:0] idx_q;
	logic signed [CB-1:0]   code_q [3];

	// Constant direction table; codes past the searched range read as zero.
	generate
		for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_tab
			for (genvar c = 0; c < 3; c++) begin : g_comp
				if (k < LIMIT) begin : g_code
					assign tab[k][c] = CB'(scaled_code(k, c, CB));
				end else begin : g_none
					assign tab[k][c] = '0;
				end
			end
		end
	endgenerate

	// Last codeword against the running best; ties keep the lower index.
	assign d_last = DW'(sq_i[0]) + DW'(sq_i[1]) + DW'(sq_i[2]);
	assign sel    = (d_last < best_d_i) ? LAST_IDX : best_idx_i;

	assign ready_o = !valid_q || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i && ready_o) begin
			idx_q <= sel;
			for (int c = 0; c < 3; c++) begin
				code_q[c] <= tab[sel][c];
			end
		end
	end

	assign valid_o = valid_q;
	assign idx_o   = idx_q;
	assign code_o  = code_q;

endmodule

[hw/rtl/normal_vector_quantizer_core.sv]
// ----------------------------------------------------------------------------
// normal_vector_quantizer_core: nearest-codeword quantizer for surface normals
// Maps each normal to the closest of a fixed set of sphere directions.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one normal per item (normal_x/y/z, signed Q1.15 scaled to
//   COMPONENT_BITS); result returns the index of the nearest codeword by
//   squared distance, lowest index on ties, and that codeword's direction.
//   Both channels move an item when valid and ready are high at a clock edge.
//   The search is a chain of one cell per codeword, min(NUM_CODES, 24) cells,
//   each squaring the distance to its own codeword while folding the previous
//   one, if any, into the running best, followed by one output stage. Each item
//   passes through the cell registers in order and then the output register;
//   one item is accepted every cycle while the receiver keeps up.
//   Every stage holds its item when the next one is full, so a stalled
//   receiver freezes only the tail; bubbles further up still fill, and sample
//   stays ready until the whole chain is full.
//   Reset clears all valid flags; no result is pending after reset and the
//   codebook is constant, so no setup is needed.
// ----------------------------------------------------------------------------
module normal_vector_quantizer_core
	import nvq_pkg::*;
#(
	parameter int NUM_CODES      = DEF_NUM_CODES,
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	nvq_sample_if.sink  sample,
	nvq_result_if.source result
);

	localparam int CB    = COMPONENT_BITS;
	localparam int SQ_W  = 2 * CB;
	localparam int DW    = 2 * CB + 2;
	localparam int LIMIT = code_limit(NUM_CODES);

	// Links between neighboring cells; link 0 is the input channel.
	logic                   valid_a    [LIMIT+1];
	logic                   ready_a    [LIMIT+1];
	logic signed [CB-1:0]   vec_a      [LIMIT+1][3];
	logic        [SQ_W-1:0] sq_a       [LIMIT+1][3];
	logic        [DW-1:0]   best_d_a   [LIMIT+1];
	logic        [IDX_W-1:0] best_idx_a [LIMIT+1];
	logic signed [CB-1:0]   code       [3];

	// Chain head: start with the largest distance, which any codeword beats.
	assign valid_a[0]    = sample.valid;
	assign sample.ready  = ready_a[0];
	assign vec_a[0][0]   = sample.normal_x;
	assign vec_a[0][1]   = sample.normal_y;
	assign vec_a[0][2]   = sample.normal_z;
	assign sq_a[0]       = '{default: '0};
	assign best_d_a[0]   = '1;
	assign best_idx_a[0] = '0;

	// One cell per codeword.
	generate
		for (genvar k = 0; k < LIMIT; k++) begin : g_cell
			nvq_cell #(
				.CODE_IDX       (k),
				.COMPONENT_BITS (CB)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.valid_i    (valid_a[k]),
				.ready_o    (ready_a[k]),
				.vec_i      (vec_a[k]),
				.sq_i       (sq_a[k]),
				.best_d_i   (best_d_a[k]),
				.best_idx_i (best_idx_a[k]),
				.valid_o    (valid_a[k+1]),
				.ready_i    (ready_a[k+1]),
				.vec_o      (vec_a[k+1]),
				.sq_o       (sq_a[k+1]),
				.best_d_o   (best_d_a[k+1]),
				.best_idx_o (best_idx_a[k+1])
			);
		end
	endgenerate

	// Final compare, direction lookup and output register.
	nvq_out_stage #(
		.NUM_CODES      (NUM_CODES),
		.COMPONENT_BITS (CB)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_i    (valid_a[LIMIT]),
		.ready_o    (ready_a[LIMIT]),
		.sq_i       (sq_a[LIMIT]),
		.best_d_i   (best_d_a[LIMIT]),
		.best_idx_i (best_idx_a[LIMIT]),
		.valid_o    (result.valid),
		.ready_i    (result.ready),
		.idx_o      (result.cluster_index),
		.code_o     (code)
	);

	assign result.code_x = code[0];
	assign result.code_y = code[1];
	assign result.code_z = code[2];

endmodule

[hw/rtl/nvq_checker.sv]
// ----------------------------------------------------------------------------
// nvq_checker: port-level checks for the normal vector quantizer
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module nvq_checker
	import nvq_pkg::*;
#(
	parameter int NUM_CODES      = DEF_NUM_CODES,
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
	localparam int CB            = COMPONENT_BITS,
	localparam int LIMIT         = code_limit(NUM_CODES)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input logic        [IDX_W-1:0] cluster_index,
	input logic signed [CB-1:0]  code_x,
	input logic signed [CB-1:0]  code_y,
	input logic signed [CB-1:0]  code_z
);

	// A stalled result item stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its index.
	a_index_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(cluster_index))
		else $error("result index changed while stalled");

	// The index stays in the searched range and the direction matches it.
	a_code_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (cluster_index < IDX_W'(LIMIT))
			&& (code_x == CB'(scaled_code(int'(cluster_index), 0, CB)))
			&& (code_y == CB'(scaled_code(int'(cluster_index), 1, CB)))
			&& (code_z == CB'(scaled_code(int'(cluster_index), 2, CB))))
		else $error("result direction does not match its index");

	// With no result pending the whole chain can move, so input is ready.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("input refused with the output empty");

endmodule

bind normal_vector_quantizer_core nvq_checker #(
	.NUM_CODES      (NUM_CODES),
	.COMPONENT_BITS (COMPONENT_BITS)
) u_nvq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_ready  (sample.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.cluster_index (result.cluster_index),
	.code_x        (result.code_x),
	.code_y        (result.code_y),
	.code_z        (result.code_z)
);
